[rtl/positional_list_insert_delete_unit_assert.svh]
// assertion macros for the positional list unit checker
// no dependencies; included by plid_checker.sv
`ifndef POSITIONAL_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_UNIT_ASSERT_SVH

// same-cycle implication under clock and active-low reset
`define PLID_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under clock and active-low reset
`define PLID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/plid_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the positional list unit
// no dependencies
package plid_pkg;

    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int ECNT_W  = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // broadcast from the control to every cell
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] idx;
    } t_cell_ctrl;

endpackage

[rtl/plid_in_if.sv]
`timescale 1ns / 1ps
// request channel: valid/ready plus op, position, value
// depends on plid_pkg
interface plid_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 op;
    logic [plid_pkg::POS_W-1:0]           position;
    logic signed [plid_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

[rtl/plid_out_if.sv]
`timescale 1ns / 1ps
// result channel: valid/ready plus status, entry count, removed value
// depends on plid_pkg
interface plid_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [plid_pkg::STAT_W-1:0]          status;
    logic [plid_pkg::ECNT_W-1:0]          entry_count;
    logic signed [plid_pkg::VALUE_W-1:0]  removed_value;

    modport source (output valid, output status, output entry_count, output removed_value,
                    input ready);
    modport sink   (input valid, input status, input entry_count, input removed_value,
                    output ready);
endinterface

[rtl/plid_cell.sv]
`timescale 1ns / 1ps
// one list slot: holds an entry and shifts with its neighbors
// depends on plid_pkg
module plid_cell #(
    parameter int INDEX = 0
) (
    input  logic                                i_clk,
    input  plid_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [plid_pkg::VALUE_W-1:0] i_new_value,
    input  logic signed [plid_pkg::VALUE_W-1:0] i_below,
    input  logic signed [plid_pkg::VALUE_W-1:0] i_above,
    output logic signed [plid_pkg::VALUE_W-1:0] o_value
);
    localparam int CW = ($clog2(INDEX + 2) > plid_pkg::POS_W) ?
                        $clog2(INDEX + 2) : plid_pkg::POS_W;

    logic [CW-1:0]                        my_idx;
    logic [CW-1:0]                        pos_idx;
    logic signed [plid_pkg::VALUE_W-1:0]  r_value;

    assign my_idx  = CW'(INDEX);
    assign pos_idx = CW'(i_ctrl.idx);

    // insert: above the slot take from below, at the slot load new
    // delete: at or above the slot take from above
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins) begin
            if (my_idx > pos_idx) begin
                r_value <= i_below;
            end else if (my_idx == pos_idx) begin
                r_value <= i_new_value;
            end
        end else if (i_ctrl.del && (my_idx >= pos_idx)) begin
            r_value <= i_above;
        end
    end

    assign o_value = r_value;
endmodule

[rtl/positional_list_insert_delete_unit.sv]
`timescale 1ns / 1ps
// top level: request decode, entry count and a row of list cells
// depends on plid_pkg, plid_in_if, plid_out_if, plid_cell
//
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of
// cells. Every request (insert at 1-based position 1..count+1, delete at
// 1..count) is handled as follows: the decode broadcasts the position to all
// cells and each cell shifts from its neighbor at the same clock edge, so a
// request is accepted every cycle while the result register can take it, and
// its result is loaded into the output register on acceptance. The output
// register is the only thing that can hold the input back: a new request is
// taken whenever the result register is empty or being drained. Status is
// done, invalid position (checked first) or full. Entries need no clearing
// after reset; positions are 5 bits wide, so at most 31 entries are ever reachable.
module positional_list_insert_delete_unit #(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    plid_in_if.sink    i_in,
    plid_out_if.source o_out
);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = ((CNT_W > plid_pkg::POS_W) ? CNT_W : plid_pkg::POS_W) + 1;
    localparam int RD_N  = (CAPACITY < 32) ? CAPACITY : 32;

    logic                                 accept;
    logic [CW-1:0]                        pos_x;
    logic [CW-1:0]                        cnt_x;
    logic [CW-1:0]                        new_cnt_x;
    logic                                 ins_bad;
    logic                                 del_bad;
    logic                                 is_full;
    plid_pkg::t_status                    status;
    plid_pkg::t_cell_ctrl                 ctrl;
    logic signed [plid_pkg::VALUE_W-1:0]  cell_val [CAPACITY];
    logic signed [plid_pkg::VALUE_W-1:0]  removed;

    logic [CNT_W-1:0]                     r_count;
    logic [CNT_W-1:0]                     n_count;
    logic                                 r_out_valid;
    logic [plid_pkg::STAT_W-1:0]          r_status;
    logic [plid_pkg::ECNT_W-1:0]          r_entry_count;
    logic signed [plid_pkg::VALUE_W-1:0]  r_removed;

    // handshake
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // position checks
    assign pos_x   = CW'(i_in.position);
    assign cnt_x   = CW'(r_count);
    assign ins_bad = (i_in.position == '0) || (pos_x > (cnt_x + CW'(1)));
    assign del_bad = (i_in.position == '0) || (pos_x > cnt_x);
    assign is_full = (r_count == CNT_W'(CAPACITY));

    // decode request into cell control, status and next count
    always_comb begin
        ctrl     = '0;
        ctrl.idx = i_in.position - plid_pkg::POS_W'(1);
        status   = plid_pkg::ST_DONE;
        n_count  = r_count;
        if (i_in.op == plid_pkg::OP_INSERT) begin
            if (ins_bad) begin
                status = plid_pkg::ST_BADPOS;
            end else if (is_full) begin
                status = plid_pkg::ST_FULL;
            end else begin
                ctrl.ins = accept;
                n_count  = r_count + CNT_W'(1);
            end
        end else begin
            if (del_bad) begin
                status = plid_pkg::ST_BADPOS;
            end else begin
                ctrl.del = accept;
                n_count  = r_count - CNT_W'(1);
            end
        end
    end

    assign new_cnt_x = CW'(n_count);

    // removed entry: select among the reachable cells
    always_comb begin
        removed = '0;
        if ((i_in.op == plid_pkg::OP_DELETE) && !del_bad) begin
            for (int k = 0; k < RD_N; k++) begin
                if (ctrl.idx == plid_pkg::POS_W'(k)) begin
                    removed = cell_val[k];
                end
            end
        end
    end

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        plid_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_new_value (i_in.value),
            .i_below     (cell_val[(g == 0) ? 0 : g - 1]),
            .i_above     (cell_val[(g == CAPACITY - 1) ? g : g + 1]),
            .o_value     (cell_val[g])
        );
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= status;
            r_entry_count <= new_cnt_x[plid_pkg::ECNT_W-1:0];
            r_removed     <= removed;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.entry_count   = r_entry_count;
    assign o_out.removed_value = r_removed;
endmodule

[rtl/plid_checker.sv]
`timescale 1ns / 1ps
// port-level checker for the positional list unit, bound to the top level
// depends on plid_pkg and positional_list_insert_delete_unit_assert.svh
`include "positional_list_insert_delete_unit_assert.svh"

module plid_checker #(
    parameter int CAPACITY = 16
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [plid_pkg::STAT_W-1:0]         i_status,
    input logic [plid_pkg::ECNT_W-1:0]         i_entry_count,
    input logic signed [plid_pkg::VALUE_W-1:0] i_removed_value
);
    localparam int CNT_W = $clog2(CAPACITY + 1) + plid_pkg::ECNT_W;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam int RES_W = 1 + plid_pkg::STAT_W + plid_pkg::ECNT_W + plid_pkg::VALUE_W;

    logic             stat_ok;
    logic             rejected;
    logic             rm_zero;
    logic             full_rep;
    logic             at_cap;
    logic             stalled;
    logic [RES_W-1:0] res_bits;

    // terms used by the properties
    assign stat_ok  = (i_status == plid_pkg::ST_DONE) || (i_status == plid_pkg::ST_BADPOS) ||
                      (i_status == plid_pkg::ST_FULL);
    assign rejected = i_out_valid && (i_status != plid_pkg::ST_DONE);
    assign rm_zero  = (i_removed_value == '0);
    assign full_rep = i_out_valid && (i_status == plid_pkg::ST_FULL);
    assign at_cap   = (i_entry_count == CAP_C[plid_pkg::ECNT_W-1:0]);
    assign stalled  = i_out_valid && !i_out_ready;
    assign res_bits = {i_out_valid, i_status, i_entry_count, i_removed_value};

    // status is one of the three defined codes
    `PLID_ASSERT_NOW(a_status_code, i_clk, i_rst_n, i_out_valid, stat_ok, "unknown status")

    // a rejected request never reports a removed entry
    `PLID_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n, rejected, rm_zero, "removed on reject")

    // full is only reported with the list at capacity
    `PLID_ASSERT_NOW(a_full_count, i_clk, i_rst_n, full_rep, at_cap, "full below capacity")

    // a stalled result holds
    `PLID_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stalled, $stable(res_bits), "stalled item changed")
endmodule

bind positional_list_insert_delete_unit plid_checker #(
    .CAPACITY (CAPACITY)
) u_plid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_status        (o_out.status),
    .i_entry_count   (o_out.entry_count),
    .i_removed_value (o_out.removed_value)
);

[verif/plid_list_checker.sv]
`timescale 1ns / 1ps
// checker for the positional list unit: watches both channels, keeps its own list
// depends on plid_pkg, plid_in_if, plid_out_if
module plid_list_checker #(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    plid_in_if   i_req,
    plid_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import plid_pkg::*;

    typedef struct {
        t_status                   status;
        logic [ECNT_W-1:0]         entry_count;
        logic signed [VALUE_W-1:0] removed_value;
    } t_list_result;

    // ordered contents of the list, index 0 is position 1
    logic signed [VALUE_W-1:0] list_vals[$];
    t_list_result              expected_results[$];
    int                        fail_total;

    // apply one request to the list copy and return what the block should answer
    function automatic t_list_result apply_request(t_op op, int unsigned pos,
                                                   logic signed [VALUE_W-1:0] val);
        t_list_result r;
        r.status        = ST_DONE;
        r.removed_value = '0;
        if (op == OP_INSERT) begin
            // position check comes before the full check
            if (pos < 1 || pos > list_vals.size() + 1) begin
                r.status = ST_BADPOS;
            end else if (list_vals.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                list_vals.insert(pos - 1, val);
            end
        end else begin
            if (pos < 1 || pos > list_vals.size()) begin
                r.status = ST_BADPOS;
            end else begin
                r.removed_value = list_vals[pos - 1];
                list_vals.delete(pos - 1);
            end
        end
        r.entry_count = ECNT_W'(list_vals.size());
        return r;
    endfunction

    // sample accepted items at the rising edge
    always @(posedge i_clk) begin : watch
        t_list_result want;
        if (!i_rst_n) begin
            list_vals.delete();
            expected_results.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                expected_results.push_back(apply_request(t_op'(i_req.op),
                                                         i_req.position, i_req.value));
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no request waiting");
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_res.status);
                        fail_total++;
                    end
                    if (i_res.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, i_res.entry_count);
                        fail_total++;
                    end
                    if (i_res.removed_value !== want.removed_value) begin
                        $error("removed_value: expected %0d, got %0d",
                               want.removed_value, i_res.removed_value);
                        fail_total++;
                    end
                end
            end
        end
        o_pending    = expected_results.size();
        o_fail_count = fail_total;
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// testbench top for the positional list unit: clock, reset, stimulus and verdict
// depends on plid_pkg, plid_in_if, plid_out_if, plid_list_checker and the unit itself
module tb;
    import plid_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int IDLE_LIMIT = 5000;
    localparam int RAND_ITEMS = 800;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    logic req_taken;
    int   idle_cycles;
    int   list_len;
    logic sender_calm;

    plid_in_if  in_ch ();
    plid_out_if out_ch ();

    positional_list_insert_delete_unit #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    plid_list_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (in_ch),
        .i_res       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request acceptance seen at the last rising edge
    always @(posedge i_clk) begin
        req_taken <= in_ch.valid && in_ch.ready;
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("positional_list_insert_delete_unit test failed");
            $finish;
        end
    end

    // gap before a request, mostly short
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_calm || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // drive one request at a falling edge and hold it until taken
    task automatic send_req(t_op op, int pos, logic signed [VALUE_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.op       <= op;
        in_ch.position <= POS_W'(pos);
        in_ch.value    <= val;
        do @(negedge i_clk); while (!req_taken);
        // track list length only to steer the stimulus
        if (op == OP_INSERT && pos >= 1 && pos <= list_len + 1 && list_len < CAPACITY) begin
            list_len++;
        end else if (op == OP_DELETE && pos >= 1 && pos <= list_len) begin
            list_len--;
        end
    endtask

    // hold the sender until every result has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // result side: random stalls with calm stretches
    initial begin : result_stalls
        int stall_left;
        int cyc;
        stall_left = 0;
        cyc        = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (((cyc / 256) % 4) != 3 && $urandom_range(0, 99) < 20) begin
                stall_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        bit filling;
        int r;
        int pos;
        t_op op;
        in_ch.valid    = 1'b0;
        in_ch.op       = OP_INSERT;
        in_ch.position = '0;
        in_ch.value    = '0;
        i_rst_n        = 1'b0;
        list_len       = 0;
        sender_calm    = 1'b0;
        filling        = 1'b1;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list and bad positions
        send_req(OP_DELETE, 1, 32'sd0);
        send_req(OP_DELETE, 0, 32'sd5);
        send_req(OP_INSERT, 0, 32'sd1);
        send_req(OP_INSERT, 2, 32'sd2);
        // insert first, last and in the middle with extreme values
        send_req(OP_INSERT, 1, 32'sh8000_0000);
        send_req(OP_INSERT, 2, 32'sh7FFF_FFFF);
        send_req(OP_INSERT, 1, -32'sd1);
        send_req(OP_INSERT, 2, 32'sd0);
        send_req(OP_INSERT, 31, 32'sd3);
        // delete middle, first and last; value is ignored on delete
        send_req(OP_DELETE, 2, 32'sh5555_AAAA);
        send_req(OP_DELETE, 1, 32'sd0);
        send_req(OP_DELETE, 2, 32'sd0);
        send_req(OP_DELETE, 2, 32'sd0);
        // fill to capacity at varied positions
        while (list_len < CAPACITY) begin
            send_req(OP_INSERT, $urandom_range(1, list_len + 1), $urandom);
        end
        // full list: valid position gives full, bad position still wins
        send_req(OP_INSERT, 5, 32'sd7);
        send_req(OP_INSERT, CAPACITY + 1, 32'sd8);
        send_req(OP_INSERT, CAPACITY + 2, 32'sd9);
        send_req(OP_INSERT, 0, 32'sd10);
        send_req(OP_DELETE, CAPACITY + 1, 32'sd0);
        send_req(OP_DELETE, 31, 32'sd0);
        send_req(OP_DELETE, CAPACITY, 32'sd0);
        drain_results();

        // random part: mostly well-formed fill and drain sweeps, some noise
        for (int i = 0; i < RAND_ITEMS; i++) begin
            sender_calm = ((i / 100) % 5) == 4;
            if (i % 250 == 249) begin
                drain_results();
            end
            if (list_len == CAPACITY) begin
                filling = ($urandom_range(0, 99) < 20);
            end else if (list_len == 0) begin
                filling = 1'b1;
            end else if ($urandom_range(0, 99) < 3) begin
                filling = ~filling;
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                op  = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_DELETE;
                pos = $urandom_range(0, 31);
            end else begin
                if (list_len == 0) begin
                    op = OP_INSERT;
                end else begin
                    op = ($urandom_range(0, 99) < (filling ? 75 : 25)) ? OP_INSERT
                                                                       : OP_DELETE;
                end
                r = $urandom_range(0, 3);
                if (r == 0) begin
                    pos = 1;
                end else if (r == 1) begin
                    pos = (op == OP_INSERT) ? list_len + 1 : list_len;
                end else begin
                    pos = $urandom_range(1, (op == OP_INSERT) ? list_len + 1 : list_len);
                end
            end
            send_req(op, pos, $urandom);
        end
        in_ch.valid <= 1'b0;

        // wait for the last results, then give the verdict
        while (pending != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("positional_list_insert_delete_unit test passed");
        end else begin
            $display("positional_list_insert_delete_unit test failed");
        end
        $finish;
    end

endmodule
